// ----- sv/free_block_bitmap_allocator_assert.svh -----
// Assertion macros used by the checker file.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FFBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffba assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define FFBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffba assertion failed");

`endif

// ----- sv/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

  // Operation codes carried on the input selector
  localparam logic [1:0] FUNC_FORMAT = 2'd0;
  localparam logic [1:0] FUNC_TOGGLE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;
  localparam logic [1:0] FUNC_LIST   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_FMT  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_DISK_SIZE = 1'b0;
  localparam logic REG_LIST_CAP  = 1'b1;

  // Where an emitted block number comes from
  typedef enum logic [1:0] {
    SRC_HELD,
    SRC_CAND,
    SRC_NONE
  } src_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;       // capture the accepted item
    logic       cur_clr;     // rewind scan, drop held result, clear count
    logic       cur_inc;     // advance row cursor
    logic       fmt_write;   // write format pattern at cursor row
    logic       set_fmt;     // set formatted flag
    logic       rd;          // issue map row read
    logic       rd_pos;      // read address from position, else cursor
    logic       tgl_write;   // write toggled row back
    logic       load_row;    // load read row into scan register
    logic       clr_bit;     // clear lowest set bit of scan register
    logic       held_load;   // hold current candidate
    logic       cnt_inc;     // one more list result delivered
    logic       emit;        // load output register
    src_t       emit_src;
    logic [1:0] emit_status;
    logic       emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       formatted;
    logic       row_any;
    logic       cur_last;
    logic       held_valid;
    logic       cap_hit;
    logic       out_free;
  } sts_t;

endpackage

// ----- sv/free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Free-block bitmap allocator. A set map bit marks a free block.
// Input stream: s_tuser selects the operation (format, toggle, find first
// free, list), s_tdata carries the block position for toggle.
// Output stream: m_tdata is the block number, m_tuser holds found and
// status, m_tlast marks the final result of an item.
// APB port: disk_size at 0x0, list_capacity at 0x4; pready is always high.
// Map rows are W = min(MAP_BITS, 32) bits wide; ROWS = ceil(MAP_BITS / W).
// Sequence after acceptance, one item at a time:
//   format: one row written per cycle; no result.
//   toggle: row read, then write back; no result.
//   find:   rows read, loaded and examined until a hit, result registered after.
//   list:   rows scanned the same way, each listed block taken from the scan row.
// s_tready is high only between items. A stalled result holds in the output
// register; the scan waits on it, while an item may be accepted as soon as
// the previous one has loaded its last result into the output register.
// Reset clears the map (per-row valid bits, no clearing pass), drops the
// formatted flag and restores disk_size 255 and list_capacity 64.
module free_block_bitmap_allocator #(
  parameter int MAP_BITS = 256,
  parameter int LIST_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffba_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] position
  input  logic [1:0]                  s_tuser,   // [1:0] func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] block_number
  output logic [2:0]                  m_tuser,   // [0] found, [2:1] status
  output logic                        m_tlast
);
  import ffba_pkg::*;

  logic [7:0] disk_size;
  logic [6:0] list_capacity;
  cmd_t       cmd;
  sts_t       sts;
  logic       out_found;
  logic [1:0] out_status;

  ffba_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .disk_size     (disk_size),
    .list_capacity (list_capacity)
  );

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_tvalid),
    .in_func   (s_tuser),
    .in_tready (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffba_dp #(
    .MAP_BITS (MAP_BITS),
    .LIST_MAX (LIST_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (s_tuser),
    .in_position   (s_tdata),
    .disk_size     (disk_size),
    .list_capacity (list_capacity),
    .out_tready    (m_tready),
    .out_tvalid    (m_tvalid),
    .out_block     (m_tdata),
    .out_found     (out_found),
    .out_status    (out_status),
    .out_last      (m_tlast)
  );

  assign m_tuser = {out_status, out_found};

endmodule

// ----- sv/ffba_regs.sv -----
`timescale 1ns / 1ps

module ffba_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffba_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [7:0]                 disk_size,
  output logic [6:0]                 list_capacity
);
  import ffba_pkg::*;

  localparam logic [7:0] DISK_SIZE_RST = 8'd255;
  localparam logic [6:0] LIST_CAP_RST  = 7'd64;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size     <= DISK_SIZE_RST;
      list_capacity <= LIST_CAP_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DISK_SIZE: disk_size     <= pwdata[7:0];
        REG_LIST_CAP:  list_capacity <= pwdata[6:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_DISK_SIZE: prdata = {24'd0, disk_size};
      REG_LIST_CAP:  prdata = {25'd0, list_capacity};
    endcase
  end

endmodule

// ----- sv/ffba_dp.sv -----
`timescale 1ns / 1ps

module ffba_dp #(
  parameter int MAP_BITS = 256,
  parameter int LIST_MAX = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  ffba_pkg::cmd_t cmd,
  output ffba_pkg::sts_t sts,
  input  logic [1:0]     in_func,
  input  logic [7:0]     in_position,
  input  logic [7:0]     disk_size,
  input  logic [6:0]     list_capacity,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [7:0]     out_block,
  output logic           out_found,
  output logic [1:0]     out_status,
  output logic           out_last
);
  import ffba_pkg::*;

  localparam int W     = (MAP_BITS < 32) ? MAP_BITS : 32;
  localparam int ROWS  = (MAP_BITS + W - 1) / W;
  localparam int SH    = $clog2(W);
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GW    = $clog2(ROWS * W + 256);
  localparam int CNT_W = $clog2(LIST_MAX + 1);

  // map storage, one row of W blocks per word
  logic [W-1:0]    mem [ROWS];
  logic [ROWS-1:0] row_ok;
  logic [W-1:0]    rd_data;
  logic            rd_ok;

  logic [1:0]       func;
  logic [7:0]       pos;
  logic             formatted;
  logic [RA_W-1:0]  cursor;
  logic [W-1:0]     row;
  logic [7:0]       held;
  logic             held_valid;
  logic [CNT_W-1:0] cnt;

  logic [7:0]      lim;
  logic [GW-1:0]   pos_g;
  logic            pos_in;
  logic [RA_W-1:0] pos_row;
  logic [SH-1:0]   pos_bit;
  logic [GW-1:0]   base;
  logic [W-1:0]    rd_val;
  logic [W-1:0]    lim_mask;
  logic [W-1:0]    fmt_pat;
  logic [SH-1:0]   low_idx;
  logic [GW-1:0]   cand_g;
  logic [6:0]      cap_eff;
  logic            wr_en;
  logic [RA_W-1:0] waddr;
  logic [W-1:0]    wdata;
  logic [RA_W-1:0] raddr;

  // search bound and toggle address
  always_comb begin
    lim     = (GW'(disk_size) < GW'(MAP_BITS)) ? disk_size : 8'(MAP_BITS);
    pos_g   = GW'(pos);
    pos_in  = pos_g < GW'(MAP_BITS);
    pos_row = RA_W'(pos_g >> SH);
    pos_bit = SH'(pos_g);
    base    = GW'(cursor) << SH;
    rd_val  = rd_ok ? rd_data : '0;
  end

  // per-bit bound masks for the cursor row
  always_comb begin
    logic [GW-1:0] g;
    for (int j = 0; j < W; j++) begin
      g           = base + GW'(j);
      lim_mask[j] = g < GW'(lim);
      fmt_pat[j]  = lim_mask[j] && (g != '0);
    end
  end

  // lowest set bit of the scan row
  always_comb begin
    low_idx = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (row[j]) low_idx = SH'(j);
    end
    cand_g = base + GW'(low_idx);
  end

  // effective list capacity
  always_comb begin
    if (list_capacity == 7'd0) cap_eff = 7'd1;
    else if (list_capacity > 7'(LIST_MAX)) cap_eff = 7'(LIST_MAX);
    else cap_eff = list_capacity;
  end

  // map write port
  assign wr_en = cmd.fmt_write || (cmd.tgl_write && pos_in);
  assign waddr = cmd.fmt_write ? cursor : pos_row;
  assign wdata = cmd.fmt_write ? fmt_pat : (rd_val ^ (W'(1) << pos_bit));
  assign raddr = cmd.rd_pos ? pos_row : cursor;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (cmd.rd) begin
      rd_data <= mem[raddr];
      rd_ok   <= row_ok[raddr];
    end
  end

  // row valid bits: an unwritten row reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (wr_en) begin
      row_ok[waddr] <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      formatted  <= 1'b0;
      cursor     <= '0;
      held_valid <= 1'b0;
      cnt        <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cmd.set_fmt) formatted <= 1'b1;
      if (cmd.cur_clr) begin
        cursor     <= '0;
        held_valid <= 1'b0;
        cnt        <= '0;
      end else begin
        if (cmd.cur_inc) cursor <= cursor + RA_W'(1);
        if (cmd.held_load) held_valid <= 1'b1;
        if (cmd.cnt_inc) cnt <= cnt + CNT_W'(1);
      end
      if (cmd.emit) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func <= in_func;
      pos  <= in_position;
    end
    if (cmd.load_row) row <= (func == FUNC_FIND) ? (rd_val & lim_mask) : rd_val;
    else if (cmd.clr_bit) row <= row & (row - W'(1));
    if (cmd.held_load) held <= cand_g[7:0];
    if (cmd.emit) begin
      unique case (cmd.emit_src)
        SRC_HELD: out_block <= held;
        SRC_CAND: out_block <= cand_g[7:0];
        default:  out_block <= 8'd0;
      endcase
      out_found  <= (cmd.emit_src != SRC_NONE);
      out_status <= cmd.emit_status;
      out_last   <= cmd.emit_last;
    end
  end

  // status to controller
  always_comb begin
    sts.func       = func;
    sts.formatted  = formatted;
    sts.row_any    = |row;
    sts.cur_last   = (cursor == RA_W'(ROWS - 1));
    sts.held_valid = held_valid;
    sts.cap_hit    = ((7'(cnt) + 7'd1) == cap_eff);
    sts.out_free   = !out_tvalid || out_tready;
  end

endmodule

// ----- sv/ffba_ctrl.sv -----
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_tvalid,
  input  logic [1:0]     in_func,
  output logic           in_tready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);
  import ffba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FMT,
    S_TRD,
    S_TWR,
    S_NF,
    S_SRD,
    S_SLD,
    S_SEX
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_tready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_src    = SRC_NONE;
    cmd.emit_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch   = 1'b1;
          cmd.cur_clr = 1'b1;
          unique case (in_func)
            FUNC_FORMAT: state_next = S_FMT;
            FUNC_TOGGLE: state_next = S_TRD;
            FUNC_FIND:   state_next = sts.formatted ? S_SRD : S_NF;
            FUNC_LIST:   state_next = S_SRD;
          endcase
        end
      end
      // one row of the format pattern per cycle
      S_FMT: begin
        cmd.fmt_write = 1'b1;
        cmd.cur_inc   = 1'b1;
        if (sts.cur_last) begin
          cmd.set_fmt = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_TRD: begin
        cmd.rd     = 1'b1;
        cmd.rd_pos = 1'b1;
        state_next = S_TWR;
      end
      S_TWR: begin
        cmd.tgl_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_NF: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOT_FMT;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SRD: begin
        cmd.rd     = 1'b1;
        state_next = S_SLD;
      end
      S_SLD: begin
        cmd.load_row = 1'b1;
        state_next   = S_SEX;
      end
      // examine the scan row
      S_SEX: begin
        if (sts.func == FUNC_FIND) begin
          if (sts.row_any) begin
            if (sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_src  = SRC_CAND;
              cmd.emit_last = 1'b1;
              state_next    = S_IDLE;
            end
          end else if (sts.cur_last) begin
            if (sts.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_NO_FREE;
              cmd.emit_last   = 1'b1;
              state_next      = S_IDLE;
            end
          end else begin
            cmd.cur_inc = 1'b1;
            state_next  = S_SRD;
          end
        end else begin
          // list: a found bit is held until the next one tells whether it ends the run
          if (sts.row_any) begin
            if (!sts.held_valid) begin
              cmd.held_load = 1'b1;
              cmd.clr_bit   = 1'b1;
            end else if (sts.out_free) begin
              cmd.emit     = 1'b1;
              cmd.emit_src = SRC_HELD;
              if (sts.cap_hit) begin
                cmd.emit_status = ST_OVERFLOW;
                cmd.emit_last   = 1'b1;
                state_next      = S_IDLE;
              end else begin
                cmd.held_load = 1'b1;
                cmd.clr_bit   = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end
            end
          end else if (sts.cur_last) begin
            if (sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (sts.held_valid) begin
                cmd.emit_src = SRC_HELD;
              end else begin
                cmd.emit_status = ST_NO_FREE;
              end
              state_next = S_IDLE;
            end
          end else begin
            cmd.cur_inc = 1'b1;
            state_next  = S_SRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ffba_checker.sv -----
`timescale 1ns / 1ps
`include "free_block_bitmap_allocator_assert.svh"

module ffba_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  // a stalled result holds
  `FFBA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // every operation keeps the block busy right after it is accepted
  `FFBA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // a result without a block number is always the only one, with block zero
  `FFBA_ASSERT_IMP(a_notfound_last, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 8'd0))

  // overflow ends a list and still carries a listed block
  `FFBA_ASSERT_IMP(a_overflow_last, m_tvalid && (m_tuser[2:1] == 2'd3), m_tlast && m_tuser[0])

endmodule

bind free_block_bitmap_allocator ffba_checker u_ffba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- verif/tb_free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps

module tb_free_block_bitmap_allocator;
  import ffba_pkg::*;

  localparam int MAP_BITS      = 256;
  localparam int LIST_MAX      = 64;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;

  // One result item as it leaves the block
  typedef struct packed {
    logic [7:0] block_number;
    logic       found;
    logic [1:0] status;
    logic       last;
  } alloc_result_t;

  // Shadow copy of the free map and registers, plus the results still owed
  class bitmap_tracker;
    bit            free_map [MAP_BITS];
    bit            formatted;
    logic [7:0]    disk_size;
    logic [6:0]    list_cap;
    alloc_result_t owed_q [$];
    int            mismatches;

    function new();
      foreach (free_map[i]) free_map[i] = 1'b0;
      formatted  = 1'b0;
      disk_size  = 8'd255;
      list_cap   = 7'd64;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_DISK_SIZE) begin
        disk_size = value[7:0];
      end else begin
        list_cap = value[6:0];
      end
    endfunction

    function void owe(logic [7:0] blk, logic fnd, logic [1:0] st, logic lst);
      alloc_result_t r;
      r.block_number = blk;
      r.found        = fnd;
      r.status       = st;
      r.last         = lst;
      owed_q.push_back(r);
    endfunction

    // Apply one accepted item to the map and queue the results it causes
    function void note_item(logic [1:0] func, logic [7:0] pos);
      int            cap;
      int            n;
      bit            overflow;
      alloc_result_t r;
      n        = 0;
      overflow = 1'b0;
      case (func)
        FUNC_FORMAT: begin
          for (int i = 0; i < MAP_BITS; i++) free_map[i] = (i >= 1 && i < disk_size);
          formatted = 1'b1;
        end
        FUNC_TOGGLE: begin
          free_map[pos] = !free_map[pos];
        end
        FUNC_FIND: begin
          if (!formatted) begin
            owe(8'd0, 1'b0, ST_NOT_FMT, 1'b1);
          end else begin
            for (int i = 0; i < disk_size && n == 0; i++) begin
              if (free_map[i]) begin
                owe(8'(i), 1'b1, ST_OK, 1'b1);
                n = 1;
              end
            end
            if (n == 0) owe(8'd0, 1'b0, ST_NO_FREE, 1'b1);
          end
        end
        default: begin
          // list: zero capacity counts as one, capped at LIST_MAX
          cap = (list_cap == 0) ? 1 : ((list_cap > LIST_MAX) ? LIST_MAX : list_cap);
          for (int i = 0; i < MAP_BITS; i++) begin
            if (free_map[i]) begin
              if (n >= cap) begin
                overflow = 1'b1;
                break;
              end
              owe(8'(i), 1'b1, ST_OK, 1'b0);
              n++;
            end
          end
          if (n == 0) begin
            owe(8'd0, 1'b0, ST_NO_FREE, 1'b1);
          end else begin
            r = owed_q.pop_back();
            r.last = 1'b1;
            if (overflow) r.status = ST_OVERFLOW;
            owed_q.push_back(r);
          end
        end
      endcase
    endfunction

    function void flag(string what, alloc_result_t want, alloc_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t MISMATCH%s: expected blk=%0d found=%0d status=%0d last=%0d, got blk=%0d found=%0d status=%0d last=%0d",
                 $time, what, want.block_number, want.found, want.status, want.last,
                 got.block_number, got.found, got.status, got.last);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      string         bad;
      bad = "";
      if (owed_q.size() == 0) begin
        flag(" (no result expected)", '0, got);
      end else begin
        want = owed_q.pop_front();
        if (got.block_number !== want.block_number) bad = {bad, " block_number"};
        if (got.found !== want.found)               bad = {bad, " found"};
        if (got.status !== want.status)             bad = {bad, " status"};
        if (got.last !== want.last)                 bad = {bad, " last"};
        if (bad != "") flag(bad, want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // [7:0] position
  logic [1:0]          s_tuser;   // [1:0] func
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;   // [7:0] block_number
  logic [2:0]          m_tuser;   // [0] found, [2:1] status
  logic                m_tlast;

  bit                  steady;    // no idling on either side
  bit                  hold_req;  // receiver holds off for a long stretch
  bitmap_tracker       tracker = new();

  free_block_bitmap_allocator #(
    .MAP_BITS(MAP_BITS),
    .LIST_MAX(LIST_MAX)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random backpressure, one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result({m_tdata, m_tuser[0], m_tuser[2:1], m_tlast});
  end

  // Offer one item, with random gaps ahead of it
  task automatic send_item(logic [1:0] func, logic [7:0] pos);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= pos;
    do @(posedge clk); while (!s_tready);
    tracker.note_item(func, pos);
  endtask

  // APB write: setup then access
  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random upper bits ride along; only the register width counts
  task automatic configure(logic [7:0] dsize, logic [6:0] cap);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_DISK_SIZE, {noise[31:8], dsize});
    write_reg(REG_LIST_CAP, {noise[24:0], cap});
  endtask

  // Stop offering, wait for every owed result, let format/toggle finish
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Toggles, finds and lists with occasional formats, positions mostly within the disk
  task automatic run_random(int count, int span);
    int         pick;
    logic [1:0] func;
    logic [7:0] pos;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8)       func = FUNC_FORMAT;
      else if (pick < 50) func = FUNC_TOGGLE;
      else if (pick < 75) func = FUNC_FIND;
      else                func = FUNC_LIST;
      pos = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(span));
      send_item(func, pos);
    end
  endtask

  // Main sequence
  initial begin
    logic [7:0] dsize;
    logic [6:0] cap;
    int         span;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = FUNC_FORMAT;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any format: not-formatted find, empty list, raw toggles
    send_item(FUNC_FIND, 8'd0);
    send_item(FUNC_LIST, 8'd0);
    send_item(FUNC_TOGGLE, 8'd0);
    send_item(FUNC_TOGGLE, 8'd255);
    send_item(FUNC_TOGGLE, 8'd5);
    send_item(FUNC_TOGGLE, 8'd128);
    send_item(FUNC_LIST, 8'd0);
    send_item(FUNC_FIND, 8'd0);
    // Format at full size, then find and a list that overflows
    send_item(FUNC_FORMAT, 8'd0);
    send_item(FUNC_FIND, 8'hFF);
    send_item(FUNC_LIST, 8'd0);
    send_item(FUNC_TOGGLE, 8'd1);
    send_item(FUNC_FIND, 8'd0);

    // Zero disk size: nothing freed, nothing found; exact-capacity list
    drain();
    configure(8'd0, 7'd3);
    send_item(FUNC_FORMAT, 8'd0);
    send_item(FUNC_FIND, 8'd0);
    send_item(FUNC_LIST, 8'd0);
    send_item(FUNC_TOGGLE, 8'd7);
    send_item(FUNC_TOGGLE, 8'd200);
    send_item(FUNC_TOGGLE, 8'd3);
    send_item(FUNC_FIND, 8'd0);
    send_item(FUNC_LIST, 8'd0);
    send_item(FUNC_TOGGLE, 8'd9);
    send_item(FUNC_LIST, 8'd0);

    // One-block disk, zero capacity treated as one
    drain();
    configure(8'd1, 7'd0);
    send_item(FUNC_FORMAT, 8'd0);
    send_item(FUNC_FIND, 8'd0);
    send_item(FUNC_TOGGLE, 8'd0);
    send_item(FUNC_TOGGLE, 8'd4);
    send_item(FUNC_FIND, 8'd0);
    send_item(FUNC_LIST, 8'd0);

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          dsize = 8'($urandom_range(2, 16));
          cap   = 7'($urandom_range(1, 8));
        end
        1: begin
          dsize = 8'd255;
          cap   = 7'd64;
        end
        2: begin
          dsize = 8'($urandom_range(1, 255));
          cap   = 7'($urandom_range(1, 64));
        end
        3: begin
          dsize = 8'd1;
          cap   = 7'd1;
        end
        4: begin
          dsize = 8'($urandom_range(17, 200));
          cap   = 7'd127;
        end
        default: begin
          dsize = 8'($urandom_range(0, 255));
          cap   = 7'd0;
        end
      endcase
      drain();
      configure(dsize, cap);
      span   = (dsize == 8'd255) ? 255 : dsize + 1;
      steady = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      if ($urandom_range(9) < 8) send_item(FUNC_FORMAT, 8'($urandom));
      if (ph == 1) repeat (4) send_item(FUNC_LIST, 8'($urandom));
      run_random(50, span);
    end
    steady = 1'b0;
    drain();

    if (tracker.owed_q.size() != 0) begin
      $display("%0d expected results never arrived", tracker.owed_q.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
